// ===== src/dos_timestamp_text_formatter_core_assert.svh =====
// Assertion macros used by the formatter checker.
`ifndef DOS_TIMESTAMP_TEXT_FORMATTER_CORE_ASSERT_SVH
`define DOS_TIMESTAMP_TEXT_FORMATTER_CORE_ASSERT_SVH

// Clocked check, quiet while reset is high.
`define DTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define DTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dtf_pkg.sv =====
// Types, codes and helper functions for the FAT timestamp text formatter.
package dtf_pkg;

  localparam logic OP_TIME = 1'b0;
  localparam logic OP_DATE = 1'b1;

  localparam logic [1:0] REG_DATE_ORDER = 2'd0;
  localparam logic [1:0] REG_DATE_SEP   = 2'd1;
  localparam logic [1:0] REG_CLOCK_24H  = 2'd2;

  localparam logic [1:0] ORDER_MDY = 2'd0;
  localparam logic [1:0] ORDER_DMY = 2'd1;
  localparam logic [1:0] ORDER_YMD = 2'd2;
  localparam logic [1:0] ORDER_YDM = 2'd3;

  localparam logic [7:0] RESET_DATE_SEP = 8'd45;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_P     = 8'h70;
  localparam logic [7:0] CHAR_M     = 8'h6d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [3:0] LEN_TIME = 4'd6;
  localparam logic [3:0] LEN_DATE = 4'd8;

  typedef struct packed {
    logic [1:0] date_order;
    logic [7:0] date_separator;
    logic       clock_24h;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
    logic [7:0] char4;
    logic [7:0] char5;
    logic [7:0] char6;
    logic [7:0] char7;
    logic [3:0] text_length;
  } out_item_t;

  // Two ASCII digits of a value below 100; tens by reciprocal multiply.
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    ones = v - 7'(tens) * 7'd10;
    return {CHAR_ZERO + 8'(tens), CHAR_ZERO + 8'(ones)};
  endfunction

endpackage

// ===== src/dtf_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct.
interface dtf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== src/dos_timestamp_text_formatter_core.sv =====
// Path: each request is registered in the input reg, then in the result reg.
// Throughput: one request per cycle while the sink is ready; the formatter between
//   the registers is a bit-field split, a small subtract and reciprocal-multiply digit split.
// Stalls: the result register holds while the sink is not ready; the input
//   register keeps taking requests while it is empty or can hand off downstream.
// Reset: clears both valid flags and loads order MM-DD-YY, '-', 12-hour mode.
module dos_timestamp_text_formatter_core (
  input  logic       clk,
  input  logic       rst,
  dtf_stream_if.sink   request,
  dtf_stream_if.source result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import dtf_pkg::*;

  cfg_t      cfg;
  logic      in_valid;
  in_item_t  in_item;
  out_item_t text_next;
  logic      out_valid;
  out_item_t out_item;
  logic      advance;

  dtf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result stage moves when it is empty or its content is being taken.
  assign advance       = !out_valid || result.ready;
  // Input stage takes a request when empty or when it hands its item on.
  assign request.ready = !in_valid || advance;

  // Input register: hold the request word for the formatter.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request.ready) begin
      in_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      in_item <= request.payload;
    end
  end

  // Field split and digit conversion happen between the two registers.
  dtf_format u_format (
    .item (in_item),
    .cfg  (cfg),
    .text (text_next)
  );

  // Result register: hold the text row until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_item <= text_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;
endmodule

// ===== src/dtf_cfg_regs.sv =====
// Configuration register bank for date order, separator and clock mode.
module dtf_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  output dtf_pkg::cfg_t cfg
);
  import dtf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.date_order     <= ORDER_MDY;
      cfg.date_separator <= RESET_DATE_SEP;
      cfg.clock_24h      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATE_ORDER: cfg.date_order     <= cfg_data[1:0];
        REG_DATE_SEP:   cfg.date_separator <= cfg_data;
        REG_CLOCK_24H:  cfg.clock_24h      <= cfg_data[0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end
endmodule

// ===== src/dtf_format.sv =====
// Combinational formatter: one time or date word to a row of ASCII text.
module dtf_format (
  input  dtf_pkg::in_item_t  item,
  input  dtf_pkg::cfg_t      cfg,
  output dtf_pkg::out_item_t text
);
  import dtf_pkg::*;

  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [4:0]  hour12;
  logic        pm;
  logic [4:0]  hour_shown;
  logic [15:0] hour_txt;
  logic [15:0] min_txt;

  logic [4:0]  day;
  logic [3:0]  month;
  logic [7:0]  year_sum;
  logic [6:0]  year;
  logic [6:0]  va, vb, vc;
  logic [15:0] a_txt, b_txt, c_txt;

  always_comb begin
    hour   = item.stamp[15:11];
    minute = item.stamp[10:5];
    pm     = (hour >= 5'd12);
    if (hour > 5'd12) begin
      hour12 = hour - 5'd12;
    end else if (hour == 5'd0) begin
      hour12 = 5'd12;
    end else begin
      hour12 = hour;
    end
    hour_shown = cfg.clock_24h ? hour : hour12;
    hour_txt   = two_digits(7'(hour_shown));
    min_txt    = two_digits(7'(minute));
  end

  always_comb begin
    day      = item.stamp[4:0];
    month    = item.stamp[8:5];
    year_sum = 8'd80 + 8'(item.stamp[15:9]);
    if (year_sum >= 8'd200) begin
      year = 7'(year_sum - 8'd200);
    end else if (year_sum >= 8'd100) begin
      year = 7'(year_sum - 8'd100);
    end else begin
      year = 7'(year_sum);
    end
    unique case (cfg.date_order)
      ORDER_DMY: begin va = 7'(day);  vb = 7'(month); vc = year;       end
      ORDER_YMD: begin va = year;     vb = 7'(month); vc = 7'(day);    end
      ORDER_YDM: begin va = year;     vb = 7'(day);   vc = 7'(month);  end
      default:   begin va = 7'(month); vb = 7'(day);  vc = year;       end
    endcase
    a_txt = two_digits(va);
    b_txt = two_digits(vb);
    c_txt = two_digits(vc);
  end

  always_comb begin
    if (item.op == OP_TIME) begin
      text.char0       = hour_txt[15:8];
      text.char1       = hour_txt[7:0];
      text.char2       = min_txt[15:8];
      text.char3       = min_txt[7:0];
      text.char4       = cfg.clock_24h ? CHAR_SPACE : (pm ? CHAR_P : CHAR_A);
      text.char5       = cfg.clock_24h ? CHAR_SPACE : CHAR_M;
      text.char6       = CHAR_NUL;
      text.char7       = CHAR_NUL;
      text.text_length = LEN_TIME;
    end else begin
      text.char0       = a_txt[15:8];
      text.char1       = a_txt[7:0];
      text.char2       = cfg.date_separator;
      text.char3       = b_txt[15:8];
      text.char4       = b_txt[7:0];
      text.char5       = cfg.date_separator;
      text.char6       = c_txt[15:8];
      text.char7       = c_txt[7:0];
      text.text_length = LEN_DATE;
    end
  end
endmodule

// ===== src/dtf_checker.sv =====
// Port-level checks on the formatter core, bound into the core module.
`include "dos_timestamp_text_formatter_core_assert.svh"

module dtf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input dtf_pkg::out_item_t text
);
  import dtf_pkg::*;

  `DTF_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")
  `DTF_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(text), "stalled result changed")
  `DTF_ASSERT(a_length_code, out_valid |-> (text.text_length == LEN_TIME || text.text_length == LEN_DATE), "bad text length")
  `DTF_ASSERT(a_time_tail, out_valid && text.text_length == LEN_TIME |-> text.char6 == CHAR_NUL && text.char7 == CHAR_NUL, "time tail not zero")
  `DTF_ASSERT(a_date_sep, out_valid && text.text_length == LEN_DATE |-> text.char2 == text.char5, "date separators differ")
endmodule

bind dos_timestamp_text_formatter_core dtf_checker u_dtf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .text      (result.payload)
);

// ===== bench/dos_timestamp_text_formatter_core_tb.sv =====
// Self-checking bench for the FAT time/date text formatter core.
module dos_timestamp_text_formatter_core_tb;
  import dtf_pkg::*;

  // Index 3 decodes to no register; writes to it must leave every setting alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Run limit: several times the slowest legal run (every request behind a long
  // sender gap and a long result stall).
  localparam int unsigned RUN_LIMIT = 5_000_000;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_REQUESTS = 215;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  dtf_stream_if #(.payload_t(in_item_t))  req_if ();
  dtf_stream_if #(.payload_t(out_item_t)) res_if ();

  dos_timestamp_text_formatter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Settings as the core should hold them, and the text rows still owed by it.
  cfg_t        shadow_cfg;
  out_item_t   pending_text[$];
  int unsigned fail_count = 0;

  // Idling controls: no_idle turns off all gaps on both sides; hold_request
  // asks the result side for one long stall of that many cycles.
  bit no_idle = 1'b0;
  int hold_request = 0;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] make_time(input int hour, input int minute, input int sec2);
    return {5'(hour), 6'(minute), 5'(sec2)};
  endfunction

  function automatic logic [15:0] make_date(input int year, input int month, input int day);
    return {7'(year), 4'(month), 5'(day)};
  endfunction

  // Two ASCII decimal digits; every field here stays below 100.
  function automatic logic [15:0] digit_pair(input int unsigned value);
    return {CHAR_ZERO + 8'(value / 10), CHAR_ZERO + 8'(value % 10)};
  endfunction

  // Build the text row the core owes for one request under the current settings.
  function automatic out_item_t format_stamp(input in_item_t req);
    out_item_t   row;
    int unsigned hour;
    int unsigned minute;
    int unsigned day;
    int unsigned month;
    int unsigned year;
    int unsigned first;
    int unsigned second;
    int unsigned third;
    logic        pm;
    row = '0;
    if (req.op == OP_TIME) begin
      hour   = req.stamp[15:11];
      minute = req.stamp[10:5];
      pm     = 1'b0;
      // Twelve-hour mode: midnight reads 12 am, noon and later read pm, and
      // hours past 12 (out-of-range ones too) drop by 12.
      if (!shadow_cfg.clock_24h) begin
        if (hour >= 12) begin
          if (hour > 12) hour -= 12;
          pm = 1'b1;
        end else if (hour == 0) begin
          hour = 12;
        end
      end
      {row.char0, row.char1} = digit_pair(hour);
      {row.char2, row.char3} = digit_pair(minute);
      if (shadow_cfg.clock_24h) begin
        row.char4 = CHAR_SPACE;
        row.char5 = CHAR_SPACE;
      end else begin
        row.char4 = pm ? CHAR_P : CHAR_A;
        row.char5 = CHAR_M;
      end
      row.text_length = LEN_TIME;
    end else begin
      day   = req.stamp[4:0];
      month = req.stamp[8:5];
      year  = (80 + req.stamp[15:9]) % 100;
      case (shadow_cfg.date_order)
        ORDER_DMY: begin
          first = day;   second = month; third = year;
        end
        ORDER_YMD: begin
          first = year;  second = month; third = day;
        end
        ORDER_YDM: begin
          first = year;  second = day;   third = month;
        end
        default: begin
          first = month; second = day;   third = year;
        end
      endcase
      {row.char0, row.char1} = digit_pair(first);
      row.char2              = shadow_cfg.date_separator;
      {row.char3, row.char4} = digit_pair(second);
      row.char5              = shadow_cfg.date_separator;
      {row.char6, row.char7} = digit_pair(third);
      row.text_length = LEN_DATE;
    end
    return row;
  endfunction

  // Write one register over a single enabled edge; mirror the width mask.
  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_DATE_ORDER: shadow_cfg.date_order     = data[1:0];
      REG_DATE_SEP:   shadow_cfg.date_separator = data;
      REG_CLOCK_24H:  shadow_cfg.clock_24h      = data[0];
      default: ;
    endcase
  endtask

  // Offer one request after a random gap; hold it until the core takes it.
  task automatic send_stamp(input logic op, input logic [15:0] stamp);
    in_item_t req;
    int       gap;
    req.op    = op;
    req.stamp = stamp;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk); while (!req_if.ready);
    pending_text.push_back(format_stamp(req));
  endtask

  // Drop valid and wait until every owed row is out, plus the pipeline depth.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reset settings: order MM-DD-YY, '-', twelve-hour clock.
  task automatic check_twelve_hour_time();
    send_stamp(OP_TIME, make_time(0, 0, 0));
    send_stamp(OP_TIME, make_time(11, 59, 29));
    send_stamp(OP_TIME, make_time(12, 0, 0));
    send_stamp(OP_TIME, make_time(13, 30, 31));
    send_stamp(OP_TIME, make_time(23, 59, 0));
    // Hour and minute beyond their legal range still show as two digits.
    send_stamp(OP_TIME, make_time(31, 63, 31));
  endtask

  task automatic check_reset_date();
    // Month 0 and day 0 are shown as is; year field 0 reads 80.
    send_stamp(OP_DATE, make_date(0, 0, 0));
    send_stamp(OP_DATE, make_date(127, 15, 31));
    // Year wraps through 99 to 00.
    send_stamp(OP_DATE, make_date(19, 12, 31));
    send_stamp(OP_DATE, make_date(20, 1, 1));
  endtask

  task automatic check_twenty_four_hour_time();
    settle();
    // Upper data bits must be masked off by the one-bit register.
    write_reg(REG_CLOCK_24H, 8'hff);
    send_stamp(OP_TIME, make_time(0, 0, 0));
    send_stamp(OP_TIME, make_time(12, 34, 0));
    send_stamp(OP_TIME, make_time(23, 59, 31));
    send_stamp(OP_TIME, make_time(31, 63, 0));
    settle();
    write_reg(REG_CLOCK_24H, 8'hfe);
  endtask

  task automatic check_date_orders();
    logic [7:0] separators[4];
    separators = '{8'h00, 8'hff, 8'h2f, 8'h2e};
    for (int order = 0; order < 4; order++) begin
      settle();
      write_reg(REG_DATE_ORDER, {6'b101010, 2'(order)});
      write_reg(REG_DATE_SEP, separators[order]);
      send_stamp(OP_DATE, make_date(25, 7, 4));
      send_stamp(OP_DATE, make_date(99, 10, 28));
    end
  endtask

  task automatic check_unused_register();
    settle();
    write_reg(REG_UNUSED, 8'hff);
    send_stamp(OP_DATE, make_date(44, 3, 17));
    send_stamp(OP_TIME, make_time(18, 5, 2));
  endtask

  // Stall the result side for a long stretch while requests keep coming
  // back to back, so the core fills and pushes back on its input.
  task automatic check_output_backpressure();
    settle();
    no_idle = 1'b1;
    hold_request = 80;
    repeat (24) send_stamp(1'($urandom), 16'($urandom));
    settle();
    no_idle = 1'b0;
  endtask

  // Random settings per phase, extremes favored; one phase runs with no gaps.
  task automatic check_random_stamps();
    int roll;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      write_reg(REG_DATE_ORDER, 8'($urandom));
      roll = $urandom_range(0, 3);
      write_reg(REG_DATE_SEP, roll == 0 ? 8'h00 : roll == 1 ? 8'hff : 8'($urandom));
      write_reg(REG_CLOCK_24H, 8'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 8'($urandom));
      no_idle = (phase == 3);
      repeat (PHASE_REQUESTS) send_stamp(1'($urandom), 16'($urandom));
    end
    settle();
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, or one long hold when asked, counted here.
  initial begin : result_sink
    int stall;
    int hold_left;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
        res_if.ready <= 1'b0;
        repeat (hold_left) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Match each accepted result against the oldest owed row.
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_text.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, got);
        fail_count++;
      end else begin
        want = pending_text.pop_front();
        compare_field("char0", want.char0, got.char0);
        compare_field("char1", want.char1, got.char1);
        compare_field("char2", want.char2, got.char2);
        compare_field("char3", want.char3, got.char3);
        compare_field("char4", want.char4, got.char4);
        compare_field("char5", want.char5, got.char5);
        compare_field("char6", want.char6, got.char6);
        compare_field("char7", want.char7, got.char7);
        compare_field("text_length", 8'(want.text_length), 8'(got.text_length));
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_sequence
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    shadow_cfg     = '{date_order: ORDER_MDY, date_separator: RESET_DATE_SEP, clock_24h: 1'b0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    check_twelve_hour_time();
    check_reset_date();
    check_twenty_four_hour_time();
    check_date_orders();
    check_unused_register();
    check_output_backpressure();
    check_random_stamps();

    // Let any stray result surface before the verdict.
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
